### rtl/vau_pkg.sv
package vau_pkg;

    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int CNT_W  = $clog2(QDEPTH + 1);

    localparam int SQRT_LAT = 32;
    localparam int DIV_LAT  = 32;
    localparam int NUM_W    = 96;
    localparam int PADDR_W  = 3;

    localparam logic [PADDR_W-1:0] ADDR_MIN_LENGTH = 3'd0;
    localparam logic [16:0]        MIN_LENGTH_RST  = 17'd1;

    localparam logic [31:0] SAT_MAX = 32'h7FFF_FFFF;
    localparam logic [31:0] SAT_MIN = 32'h8000_0000;

    typedef enum logic [2:0] {
        CMD_ADD   = 3'd0,
        CMD_DOT   = 3'd1,
        CMD_CROSS = 3'd2,
        CMD_NORM  = 3'd3,
        CMD_LEN   = 3'd4,
        CMD_PROJ  = 3'd5
    } t_cmd;

    typedef enum logic [2:0] {
        OP_NOP   = 3'd0,
        OP_ADD   = 3'd1,
        OP_DOT   = 3'd2,
        OP_CROSS = 3'd3,
        OP_NORM  = 3'd4,
        OP_LEN   = 3'd5,
        OP_PROJ  = 3'd6
    } t_op;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_SHORT = 2'd1,
        ST_SAT   = 2'd2
    } t_status;

    typedef struct packed {
        logic [2:0]         cmd;
        logic signed [31:0] a_x;
        logic signed [31:0] a_y;
        logic signed [31:0] a_z;
        logic signed [31:0] b_x;
        logic signed [31:0] b_y;
        logic signed [31:0] b_z;
    } t_in_beat;

    typedef struct packed {
        logic signed [31:0] r_x;
        logic signed [31:0] r_y;
        logic signed [31:0] r_z;
        logic signed [31:0] scalar;
        logic [1:0]         status;
    } t_out_beat;

    typedef struct packed {
        t_op             op;
        logic [2:0][31:0] a;
        logic [2:0][31:0] b;
    } t_qitem;

    // Clamp a sign and magnitude pair to 32-bit two's complement; bit 32 flags a clamp.
    function automatic logic [32:0] sat32(input logic neg, input logic [63:0] mag);
        logic [32:0] res;
        if (neg) begin
            if (mag > {32'b0, SAT_MIN}) begin
                res = {1'b1, SAT_MIN};
            end else begin
                res = {1'b0, 32'(~mag[31:0] + 32'd1)};
            end
        end else if (mag > {32'b0, SAT_MAX}) begin
            res = {1'b1, SAT_MAX};
        end else begin
            res = {1'b0, mag[31:0]};
        end
        return res;
    endfunction

endpackage

### rtl/vector3_arith_unit.sv
// Fixed-point 3-vector arithmetic unit.
// The input channel (i_in_valid, o_in_stall, i_in_beat) carries one command
// per beat with two signed vectors a and b; the output channel (o_out_valid,
// i_out_stall, o_out_beat) returns exactly one result beat per command, in
// order. A beat moves at a clock edge where valid is high and stall is low.
// Accepted beats enter a four-entry queue; the execution pipeline drains it.
// It is made of the 32-stage square root pipeline followed by the 32-stage
// divider pipeline, plus six staging registers. One command is taken every
// cycle for any mix of operations while the receiver does not stall a valid
// output beat.
// When the receiver stalls, the whole execution pipeline holds and the queue
// absorbs up to four more beats before o_in_stall rises.
// The APB port holds min_length at address 0; pready is always high.
// A synchronous active-low reset empties the queue and pipeline and sets
// min_length to one.
module vector3_arith_unit import vau_pkg::*; #(
    parameter int FRAC_BITS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  t_in_beat           i_in_beat,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output t_out_beat          o_out_beat,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    logic [16:0] r_min_length;
    logic        w_take;
    logic        w_q_valid;
    t_qitem      w_q_item;

    assign pready = 1'b1;
    assign prdata = (paddr == ADDR_MIN_LENGTH) ? {15'b0, r_min_length} : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_length <= MIN_LENGTH_RST;
        end else if (psel && penable && pwrite && paddr == ADDR_MIN_LENGTH) begin
            r_min_length <= pwdata[16:0];
        end
    end

    vau_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_in_beat  (i_in_beat),
        .o_in_stall (o_in_stall),
        .i_take     (w_take),
        .o_q_valid  (w_q_valid),
        .o_q_item   (w_q_item)
    );

    vau_back #(
        .FRAC_BITS (FRAC_BITS)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_min_length (r_min_length),
        .i_q_valid    (w_q_valid),
        .i_q_item     (w_q_item),
        .o_take       (w_take),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_out_beat   (o_out_beat)
    );

endmodule

### rtl/vau_front.sv
module vau_front import vau_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    input  t_in_beat i_in_beat,
    output logic     o_in_stall,
    input  logic     i_take,
    output logic     o_q_valid,
    output t_qitem   o_q_item
);

    t_qitem            r_mem [QDEPTH];
    logic [QPTR_W-1:0] r_wr;
    logic [QPTR_W-1:0] r_rd;
    logic [CNT_W-1:0]  r_cnt;
    logic [CNT_W-1:0]  n_cnt;
    logic              w_push;
    logic              w_pop;
    t_qitem            n_item;

    assign o_in_stall = (r_cnt == CNT_W'(QDEPTH));
    assign o_q_valid  = (r_cnt != '0);
    assign o_q_item   = r_mem[r_rd];
    assign w_push     = i_in_valid && !o_in_stall;
    assign w_pop      = i_take && o_q_valid;

    always_comb begin
        n_item.a = {i_in_beat.a_z, i_in_beat.a_y, i_in_beat.a_x};
        n_item.b = {i_in_beat.b_z, i_in_beat.b_y, i_in_beat.b_x};
        unique case (i_in_beat.cmd)
            CMD_ADD:   n_item.op = OP_ADD;
            CMD_DOT:   n_item.op = OP_DOT;
            CMD_CROSS: n_item.op = OP_CROSS;
            CMD_NORM:  n_item.op = OP_NORM;
            CMD_LEN:   n_item.op = OP_LEN;
            CMD_PROJ:  n_item.op = OP_PROJ;
            default:   n_item.op = OP_NOP;
        endcase
    end

    always_comb begin
        case ({w_push, w_pop})
            2'b10:   n_cnt = r_cnt + CNT_W'(1);
            2'b01:   n_cnt = r_cnt - CNT_W'(1);
            default: n_cnt = r_cnt;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
            if (w_push) begin
                r_wr <= r_wr + QPTR_W'(1);
            end
            if (w_pop) begin
                r_rd <= r_rd + QPTR_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr] <= n_item;
        end
    end

`ifndef SYNTHESIS
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_W'(QDEPTH))
        else $error("queue count above depth");
    a_cnt_inc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push && !w_pop |=> r_cnt == $past(r_cnt) + CNT_W'(1))
        else $error("queue count did not follow a push");
    a_ptr_meet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == '0 || r_cnt == CNT_W'(QDEPTH)) |-> r_rd == r_wr)
        else $error("queue pointers disagree with count");
`endif

endmodule

### rtl/vau_isqrt.sv
module vau_isqrt import vau_pkg::*; (
    input  logic        i_clk,
    input  logic        i_en,
    input  logic [63:0] i_val,
    output logic [31:0] o_root
);

    logic [33:0] r_rem  [SQRT_LAT];
    logic [31:0] r_root [SQRT_LAT];
    logic [63:0] r_rest [SQRT_LAT];

    for (genvar g = 0; g < SQRT_LAT; g++) begin : g_stage
        logic [33:0] w_rem_in;
        logic [31:0] w_root_in;
        logic [63:0] w_rest_in;
        logic [35:0] w_cur;
        logic [35:0] w_trial;

        if (g == 0) begin : g_first
            assign w_rem_in  = '0;
            assign w_root_in = '0;
            assign w_rest_in = i_val;
        end else begin : g_next
            assign w_rem_in  = r_rem[g-1];
            assign w_root_in = r_root[g-1];
            assign w_rest_in = r_rest[g-1];
        end

        assign w_cur   = {w_rem_in, w_rest_in[63:62]};
        assign w_trial = {2'b00, w_root_in, 2'b01};

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (w_cur >= w_trial) begin
                    r_rem[g]  <= 34'(w_cur - w_trial);
                    r_root[g] <= {w_root_in[30:0], 1'b1};
                end else begin
                    r_rem[g]  <= w_cur[33:0];
                    r_root[g] <= {w_root_in[30:0], 1'b0};
                end
                r_rest[g] <= {w_rest_in[61:0], 2'b00};
            end
        end
    end

    assign o_root = r_root[SQRT_LAT-1];

endmodule

### rtl/vau_div.sv
module vau_div import vau_pkg::*; (
    input  logic             i_clk,
    input  logic             i_en,
    input  logic [NUM_W-1:0] i_num,
    input  logic [63:0]      i_den,
    output logic [31:0]      o_quo
);

    logic [63:0] r_rem  [DIV_LAT];
    logic [31:0] r_rest [DIV_LAT];
    logic [31:0] r_quo  [DIV_LAT];
    logic [63:0] r_den  [DIV_LAT];

    for (genvar g = 0; g < DIV_LAT; g++) begin : g_stage
        logic [63:0] w_rem_in;
        logic [31:0] w_rest_in;
        logic [31:0] w_quo_in;
        logic [63:0] w_den_in;
        logic [64:0] w_cur;

        if (g == 0) begin : g_first
            assign w_rem_in  = i_num[NUM_W-1:32];
            assign w_rest_in = i_num[31:0];
            assign w_quo_in  = '0;
            assign w_den_in  = i_den;
        end else begin : g_next
            assign w_rem_in  = r_rem[g-1];
            assign w_rest_in = r_rest[g-1];
            assign w_quo_in  = r_quo[g-1];
            assign w_den_in  = r_den[g-1];
        end

        assign w_cur = {w_rem_in, w_rest_in[31]};

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (w_cur >= {1'b0, w_den_in}) begin
                    r_rem[g] <= 64'(w_cur - {1'b0, w_den_in});
                    r_quo[g] <= {w_quo_in[30:0], 1'b1};
                end else begin
                    r_rem[g] <= w_cur[63:0];
                    r_quo[g] <= {w_quo_in[30:0], 1'b0};
                end
                r_rest[g] <= {w_rest_in[30:0], 1'b0};
                r_den[g]  <= w_den_in;
            end
        end
    end

    assign o_quo = r_quo[DIV_LAT-1];

endmodule

### rtl/vau_back.sv
module vau_back import vau_pkg::*; #(
    parameter int FRAC_BITS = 16
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic [16:0] i_min_length,
    input  logic      i_q_valid,
    input  t_qitem    i_q_item,
    output logic      o_take,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_beat o_out_beat
);

    localparam int NSTG = 4 + SQRT_LAT + 1 + DIV_LAT + 1;

    typedef struct packed {
        t_op                   op;
        logic [2:0][31:0]      a;
        logic [2:0]            bneg;
        logic                  dneg;
        logic [2:0][NUM_W-1:0] num;
        logic [63:0]           s;
        t_out_beat             early;
    } t_side;

    typedef struct packed {
        t_op              op;
        logic [2:0][31:0] a;
        logic [2:0]       qneg;
        logic             refuse;
        t_out_beat        early;
    } t_mid;

    logic            w_en;
    logic [NSTG-1:0] r_vld;

    t_op                r1_op;
    logic [2:0][31:0]   r1_a;
    logic [2:0][31:0]   r1_b;
    logic signed [63:0] r1_p [6];
    logic [31:0]        w_ml [6];
    logic [31:0]        w_mr [6];

    t_op                r2_op;
    logic [2:0][31:0]   r2_a;
    logic [2:0][31:0]   r2_b;
    logic signed [65:0] r2_dot;
    logic signed [64:0] r2_c [3];
    logic [63:0]        r2_s;

    logic               w_dneg;
    logic [65:0]        w_dotabs;
    logic [63:0]        w_dm;
    logic [32:0]        w_sat_dot;
    logic signed [32:0] w_sum [3];
    logic [32:0]        w_smag [3];
    logic [32:0]        w_sat_add [3];
    logic [64:0]        w_cabs [3];
    logic [32:0]        w_sat_cr [3];
    logic [31:0]        w_bmag [3];
    t_out_beat          w_early;

    t_op              r3_op;
    logic [2:0][31:0] r3_a;
    logic [2:0]       r3_bneg;
    logic             r3_dneg;
    logic [63:0]      r3_s;
    logic [63:0]      r3_pl [3];
    logic [63:0]      r3_ph [3];
    t_out_beat        r3_early;

    t_side       r4;
    t_side       r_sd [SQRT_LAT];
    t_side       w_sdo;
    logic [31:0] w_len;
    logic        w_short;
    logic [32:0] w_lensat;
    logic [31:0] w_amag [3];

    t_mid                  n5_mid;
    logic [2:0][NUM_W-1:0] n5_num;
    logic [63:0]           n5_den;
    t_mid                  r5_mid;
    logic [2:0][NUM_W-1:0] r5_num;
    logic [63:0]           r5_den;

    t_mid        r_md [DIV_LAT];
    t_mid        w_mdo;
    logic [31:0] w_quo [3];
    logic [32:0] w_qsat [3];
    t_out_beat   n_out;
    t_out_beat   r_out;

    assign w_en        = !r_vld[NSTG-1] || !i_out_stall;
    assign o_take      = w_en;
    assign o_out_valid = r_vld[NSTG-1];
    assign o_out_beat  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[NSTG-2:0], i_q_valid};
        end
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_ml[i]     = i_q_item.a[i];
            w_mr[i]     = i_q_item.b[i];
            w_ml[3 + i] = i_q_item.a[i];
            w_mr[3 + i] = i_q_item.a[i];
        end
        case (i_q_item.op)
            OP_CROSS: begin
                w_ml[0] = i_q_item.a[1]; w_mr[0] = i_q_item.b[2];
                w_ml[1] = i_q_item.a[2]; w_mr[1] = i_q_item.b[1];
                w_ml[2] = i_q_item.a[2]; w_mr[2] = i_q_item.b[0];
                w_ml[3] = i_q_item.a[0]; w_mr[3] = i_q_item.b[2];
                w_ml[4] = i_q_item.a[0]; w_mr[4] = i_q_item.b[1];
                w_ml[5] = i_q_item.a[1]; w_mr[5] = i_q_item.b[0];
            end
            OP_PROJ: begin
                for (int i = 0; i < 3; i++) begin
                    w_ml[3 + i] = i_q_item.b[i];
                    w_mr[3 + i] = i_q_item.b[i];
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r1_op <= i_q_item.op;
            r1_a  <= i_q_item.a;
            r1_b  <= i_q_item.b;
            for (int k = 0; k < 6; k++) begin
                r1_p[k] <= $signed(w_ml[k]) * $signed(w_mr[k]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r2_op   <= r1_op;
            r2_a    <= r1_a;
            r2_b    <= r1_b;
            r2_dot  <= r1_p[0] + r1_p[1] + r1_p[2];
            r2_c[0] <= r1_p[0] - r1_p[1];
            r2_c[1] <= r1_p[2] - r1_p[3];
            r2_c[2] <= r1_p[4] - r1_p[5];
            r2_s    <= 64'(r1_p[3] + r1_p[4] + r1_p[5]);
        end
    end

    always_comb begin
        w_dneg    = r2_dot[65];
        w_dotabs  = w_dneg ? 66'(-r2_dot) : 66'(r2_dot);
        w_dm      = w_dotabs[63:0];
        w_sat_dot = sat32(w_dneg, w_dm >> FRAC_BITS);
        for (int i = 0; i < 3; i++) begin
            w_sum[i]     = $signed(r2_a[i]) + $signed(r2_b[i]);
            w_smag[i]    = w_sum[i][32] ? 33'(-w_sum[i]) : 33'(w_sum[i]);
            w_sat_add[i] = sat32(w_sum[i][32], {31'b0, w_smag[i]});
            w_cabs[i]    = r2_c[i][64] ? 65'(-r2_c[i]) : 65'(r2_c[i]);
            w_sat_cr[i]  = sat32(r2_c[i][64], w_cabs[i][63:0] >> FRAC_BITS);
            w_bmag[i]    = r2_b[i][31] ? 32'(-r2_b[i]) : r2_b[i];
        end
        w_early        = '0;
        w_early.status = ST_OK;
        case (r2_op)
            OP_ADD: begin
                w_early.r_x = w_sat_add[0][31:0];
                w_early.r_y = w_sat_add[1][31:0];
                w_early.r_z = w_sat_add[2][31:0];
                if (w_sat_add[0][32] || w_sat_add[1][32] || w_sat_add[2][32]) begin
                    w_early.status = ST_SAT;
                end
            end
            OP_DOT: begin
                w_early.scalar = w_sat_dot[31:0];
                if (w_sat_dot[32]) begin
                    w_early.status = ST_SAT;
                end
            end
            OP_CROSS: begin
                w_early.r_x = w_sat_cr[0][31:0];
                w_early.r_y = w_sat_cr[1][31:0];
                w_early.r_z = w_sat_cr[2][31:0];
                if (w_sat_cr[0][32] || w_sat_cr[1][32] || w_sat_cr[2][32]) begin
                    w_early.status = ST_SAT;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r3_op    <= r2_op;
            r3_a     <= r2_a;
            r3_dneg  <= w_dneg;
            r3_s     <= r2_s;
            r3_early <= w_early;
            for (int i = 0; i < 3; i++) begin
                r3_bneg[i] <= r2_b[i][31];
                r3_pl[i]   <= w_bmag[i] * w_dm[31:0];
                r3_ph[i]   <= w_bmag[i] * w_dm[63:32];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r4.op    <= r3_op;
            r4.a     <= r3_a;
            r4.bneg  <= r3_bneg;
            r4.dneg  <= r3_dneg;
            r4.s     <= r3_s;
            r4.early <= r3_early;
            for (int i = 0; i < 3; i++) begin
                r4.num[i] <= {32'b0, r3_pl[i]} + {r3_ph[i], 32'b0};
            end
        end
    end

    vau_isqrt u_isqrt (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_val  (r4.s),
        .o_root (w_len)
    );

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_sd[0] <= r4;
            for (int k = 1; k < SQRT_LAT; k++) begin
                r_sd[k] <= r_sd[k-1];
            end
        end
    end

    assign w_sdo = r_sd[SQRT_LAT-1];

    always_comb begin
        w_short  = w_len < {15'b0, i_min_length};
        w_lensat = sat32(1'b0, {32'b0, w_len});
        for (int i = 0; i < 3; i++) begin
            w_amag[i] = w_sdo.a[i][31] ? 32'(-w_sdo.a[i]) : w_sdo.a[i];
        end
        n5_mid.op     = w_sdo.op;
        n5_mid.a      = w_sdo.a;
        n5_mid.qneg   = '0;
        n5_mid.refuse = 1'b0;
        n5_mid.early  = w_sdo.early;
        n5_num        = w_sdo.num;
        n5_den        = w_sdo.s;
        case (w_sdo.op)
            OP_NORM: begin
                n5_mid.refuse = (w_len == '0) || w_short;
                n5_den        = {32'b0, w_len};
                for (int i = 0; i < 3; i++) begin
                    n5_num[i]      = {64'b0, w_amag[i]} << FRAC_BITS;
                    n5_mid.qneg[i] = w_sdo.a[i][31];
                end
            end
            OP_PROJ: begin
                n5_mid.refuse = (w_sdo.s == '0) || w_short;
                for (int i = 0; i < 3; i++) begin
                    n5_mid.qneg[i] = w_sdo.dneg ^ w_sdo.bneg[i];
                end
            end
            OP_LEN: begin
                n5_mid.early.scalar = w_lensat[31:0];
                if (w_lensat[32]) begin
                    n5_mid.early.status = ST_SAT;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r5_mid <= n5_mid;
            r5_num <= n5_num;
            r5_den <= n5_den;
        end
    end

    for (genvar g = 0; g < 3; g++) begin : g_lane
        vau_div u_div (
            .i_clk (i_clk),
            .i_en  (w_en),
            .i_num (r5_num[g]),
            .i_den (r5_den),
            .o_quo (w_quo[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_md[0] <= r5_mid;
            for (int k = 1; k < DIV_LAT; k++) begin
                r_md[k] <= r_md[k-1];
            end
        end
    end

    assign w_mdo = r_md[DIV_LAT-1];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_qsat[i] = sat32(w_mdo.qneg[i], {32'b0, w_quo[i]});
        end
        n_out = w_mdo.early;
        if (w_mdo.op == OP_NORM || w_mdo.op == OP_PROJ) begin
            n_out = '0;
            if (w_mdo.refuse) begin
                n_out.status = ST_SHORT;
                if (w_mdo.op == OP_NORM) begin
                    n_out.r_x = w_mdo.a[0];
                    n_out.r_y = w_mdo.a[1];
                    n_out.r_z = w_mdo.a[2];
                end
            end else begin
                n_out.r_x = w_qsat[0][31:0];
                n_out.r_y = w_qsat[1][31:0];
                n_out.r_z = w_qsat[2][31:0];
                if (w_qsat[0][32] || w_qsat[1][32] || w_qsat[2][32]) begin
                    n_out.status = ST_SAT;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_out <= n_out;
        end
    end

`ifndef SYNTHESIS
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_en |=> $stable(r_vld))
        else $error("pipeline moved while the output beat was stalled");
    a_sat_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[NSTG-1] && r_out.status == ST_SAT |->
            (r_out.r_x == SAT_MAX || r_out.r_x == SAT_MIN ||
             r_out.r_y == SAT_MAX || r_out.r_y == SAT_MIN ||
             r_out.r_z == SAT_MAX || r_out.r_z == SAT_MIN ||
             r_out.scalar == SAT_MAX || r_out.scalar == SAT_MIN))
        else $error("saturated status without a clamped field");
    a_short_scalar: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[NSTG-1] && r_out.status == ST_SHORT |-> r_out.scalar == '0)
        else $error("refused command carries a scalar");
`endif

endmodule
